// ----- rtl/aacr_pkg.sv -----
// Shared constants, types and register codes of the alpha-aware RGBA convolution core.
package aacr_pkg;

    // Longest window; the element that reaches this count closes the window.
    localparam int MAX_TAPS = 1024;
    localparam int TAP_W    = $clog2(MAX_TAPS + 1);

    // Field widths.
    localparam int PIX_W    = 8;
    localparam int WGT_W    = 13;
    localparam int DIV_W    = 21;
    localparam int BIAS_W   = 11;
    localparam int MASK_W   = 4;
    localparam int NUM_CH   = 4;

    // Datapath widths. Sums stay below 2^31 in magnitude for any window.
    localparam int PROD_W   = PIX_W + 1 + WGT_W;
    localparam int SUM_W    = 32;
    localparam int RDIV_W   = 24;
    localparam int MAG_W    = SUM_W - 1;
    localparam int REM_W    = RDIV_W + 1;
    localparam int CNT_W    = $clog2(MAG_W + 1);

    // Job queue between the accumulator and the divider.
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    // Channel positions, also the bit positions of the channel mask.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 2'd2;
    localparam logic signed [DIV_W-1:0]  DIVISOR_RST = 21'sd256;
    localparam logic signed [BIAS_W-1:0] BIAS_RST    = 11'sd0;
    localparam logic [MASK_W-1:0]        MASK_RST    = 4'hF;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_pix;

    // One finished window handed from the front to the back.
    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sums;
        logic [RDIV_W-1:0]            rdiv;
        t_pix                         center;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- rtl/alpha_aware_convolution_rgba_core.sv -----
// Top level of the alpha-aware RGBA convolution core: configuration registers and wiring.
// Input words are taken one per cycle while the two-entry job queue has room.
// The back end takes one window at a time through its 31-step shared-counter divider,
// skipping the division and copying the center pixel when the running divisor is zero,
// while the queue lets the front keep taking words.
// Reset is synchronous and active low; it empties the queue, drops any open window and
// any pending result, and restores divisor 256, bias 0 and all four channels selected.
module alpha_aware_convolution_rgba_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Window word channel.
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [aacr_pkg::PIX_W-1:0]             i_red,
    input  logic [aacr_pkg::PIX_W-1:0]             i_green,
    input  logic [aacr_pkg::PIX_W-1:0]             i_blue,
    input  logic [aacr_pkg::PIX_W-1:0]             i_alpha,
    input  logic signed [aacr_pkg::WGT_W-1:0]      i_weight,
    input  logic                                  i_is_center,
    input  logic                                  i_last,
    // Result word channel.
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [aacr_pkg::PIX_W-1:0]             o_out_red,
    output logic [aacr_pkg::PIX_W-1:0]             o_out_green,
    output logic [aacr_pkg::PIX_W-1:0]             o_out_blue,
    output logic [aacr_pkg::PIX_W-1:0]             o_out_alpha,
    output logic                                  o_copied,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [aacr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [aacr_pkg::DIV_W-1:0]             i_cfg_data
);

    // The divisor is sampled by the front when a window opens and by the back for
    // alpha. Bias and the channel mask are only used by the back when a result is
    // formed. The registers are expected to change only while the core is idle.
    logic signed [aacr_pkg::DIV_W-1:0]  r_divisor;
    logic signed [aacr_pkg::BIAS_W-1:0] r_bias;
    logic [aacr_pkg::MASK_W-1:0]        r_mask;

    aacr_pkg::t_qstat qstat;
    aacr_pkg::t_job   push_job;
    aacr_pkg::t_job   head_job;
    aacr_pkg::t_pix   out_pix;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= aacr_pkg::DIVISOR_RST;
            r_bias    <= aacr_pkg::BIAS_RST;
            r_mask    <= aacr_pkg::MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aacr_pkg::CFG_DIVISOR: r_divisor <= $signed(i_cfg_data);
                aacr_pkg::CFG_BIAS:    r_bias    <= $signed(i_cfg_data[aacr_pkg::BIAS_W-1:0]);
                aacr_pkg::CFG_MASK:    r_mask    <= i_cfg_data[aacr_pkg::MASK_W-1:0];
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    // Front: sums one word per cycle while the queue has room; each closed window is a job.
    aacr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_alpha     (i_alpha),
        .i_weight    (i_weight),
        .i_is_center (i_is_center),
        .i_last      (i_last),
        .i_divisor   (r_divisor),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Queue: lets the front keep taking words while the divider is busy.
    aacr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    // Back: divides, adds bias, clamps and holds the result word until taken.
    aacr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qstat   (qstat),
        .i_job     (head_job),
        .o_pop     (pop),
        .i_divisor (r_divisor),
        .i_bias    (r_bias),
        .i_mask    (r_mask),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pix     (out_pix),
        .o_copied  (o_copied)
    );

    assign o_out_red   = out_pix[aacr_pkg::CH_RED];
    assign o_out_green = out_pix[aacr_pkg::CH_GREEN];
    assign o_out_blue  = out_pix[aacr_pkg::CH_BLUE];
    assign o_out_alpha = out_pix[aacr_pkg::CH_ALPHA];

endmodule

// ----- rtl/aacr_front.sv -----
// Accumulator front: takes window words, keeps the sums, running divisor and center pixel.
module aacr_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [aacr_pkg::PIX_W-1:0]        i_red,
    input  logic [aacr_pkg::PIX_W-1:0]        i_green,
    input  logic [aacr_pkg::PIX_W-1:0]        i_blue,
    input  logic [aacr_pkg::PIX_W-1:0]        i_alpha,
    input  logic signed [aacr_pkg::WGT_W-1:0] i_weight,
    input  logic                             i_is_center,
    input  logic                             i_last,
    input  logic signed [aacr_pkg::DIV_W-1:0] i_divisor,
    input  aacr_pkg::t_qstat                 i_qstat,
    output logic                             o_push,
    output aacr_pkg::t_job                   o_job
);

    logic                                   r_open;
    logic [aacr_pkg::TAP_W-1:0]             r_taps;
    logic [aacr_pkg::NUM_CH-1:0][aacr_pkg::SUM_W-1:0] r_sum;
    logic signed [aacr_pkg::RDIV_W-1:0]     r_rdiv;
    aacr_pkg::t_pix                         r_center;

    logic [aacr_pkg::NUM_CH-1:0][aacr_pkg::SUM_W-1:0] n_sum;
    logic signed [aacr_pkg::RDIV_W-1:0]     n_rdiv;
    aacr_pkg::t_pix                         n_center;
    logic [aacr_pkg::TAP_W-1:0]             base_taps;
    aacr_pkg::t_pix                         pix;
    logic signed [aacr_pkg::PROD_W-1:0]     prod;
    logic                                   accept;
    logic                                   close;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign pix     = {i_alpha, i_blue, i_green, i_red};

    always_comb begin
        prod      = '0;
        base_taps = r_open ? r_taps : '0;
        // A closed window restarts from zero sums and the configured divisor.
        n_rdiv    = r_open ? r_rdiv : aacr_pkg::RDIV_W'(i_divisor);
        n_center  = r_open ? r_center : '0;
        for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
            n_sum[ch] = r_open ? r_sum[ch] : '0;
        end
        if (i_alpha == '0) begin
            n_rdiv = n_rdiv - aacr_pkg::RDIV_W'(i_weight);
        end else begin
            for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
                prod      = $signed({1'b0, pix[ch]}) * i_weight;
                n_sum[ch] = n_sum[ch] + aacr_pkg::SUM_W'(prod);
            end
        end
        if (i_is_center) begin
            n_center = pix;
        end
        close = i_last || (base_taps == aacr_pkg::TAP_W'(aacr_pkg::MAX_TAPS - 1));
    end

    assign o_push = accept && close;
    assign o_job  = '{sums: n_sum, rdiv: n_rdiv, center: n_center};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_taps <= '0;
        end else if (accept) begin
            r_open <= !close;
            r_taps <= base_taps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum    <= n_sum;
            r_rdiv   <= n_rdiv;
            r_center <= n_center;
        end
    end

endmodule

// ----- rtl/aacr_queue.sv -----
// Short job queue that decouples the accumulator from the divider.
module aacr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  aacr_pkg::t_job   i_job,
    input  logic             i_pop,
    output aacr_pkg::t_job   o_job,
    output aacr_pkg::t_qstat o_qstat
);

    aacr_pkg::t_job              r_mem [aacr_pkg::Q_DEPTH];
    logic [aacr_pkg::QPTR_W-1:0] r_wr;
    logic [aacr_pkg::QPTR_W-1:0] r_rd;
    logic [aacr_pkg::QCNT_W-1:0] r_cnt;

    function automatic logic [aacr_pkg::QPTR_W-1:0] next_ptr(
        input logic [aacr_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == aacr_pkg::QPTR_W'(aacr_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign o_job         = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == aacr_pkg::QCNT_W'(aacr_pkg::Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- rtl/aacr_back.sv -----
// Divider back end: four restoring dividers, bias, clamp, channel select and output register.
module aacr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aacr_pkg::t_qstat                  i_qstat,
    input  aacr_pkg::t_job                    i_job,
    output logic                              o_pop,
    input  logic signed [aacr_pkg::DIV_W-1:0]  i_divisor,
    input  logic signed [aacr_pkg::BIAS_W-1:0] i_bias,
    input  logic [aacr_pkg::MASK_W-1:0]        i_mask,
    output logic                              o_valid,
    input  logic                              i_ready,
    output aacr_pkg::t_pix                    o_pix,
    output logic                              o_copied
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam int RES_W = aacr_pkg::MAG_W + 2;

    logic [1:0]                      r_state;
    logic [aacr_pkg::CNT_W-1:0]      r_cnt;
    logic [aacr_pkg::MAG_W-1:0]      r_num [aacr_pkg::NUM_CH];
    logic [aacr_pkg::REM_W-1:0]      r_rem [aacr_pkg::NUM_CH];
    logic [aacr_pkg::MAG_W-1:0]      r_q   [aacr_pkg::NUM_CH];
    logic [aacr_pkg::RDIV_W-1:0]     r_den [aacr_pkg::NUM_CH];
    logic [aacr_pkg::NUM_CH-1:0]     r_neg;
    logic                            r_copy;
    aacr_pkg::t_pix                  r_center;
    logic                            r_out_valid;
    aacr_pkg::t_pix                  r_out_pix;
    logic                            r_out_copied;

    logic [aacr_pkg::REM_W-1:0]      rem_sh [aacr_pkg::NUM_CH];
    logic [aacr_pkg::NUM_CH-1:0]     ge;
    logic [aacr_pkg::MAG_W-1:0]      ld_num [aacr_pkg::NUM_CH];
    logic [aacr_pkg::RDIV_W-1:0]     ld_den [aacr_pkg::NUM_CH];
    logic [aacr_pkg::NUM_CH-1:0]     ld_neg;
    logic signed [aacr_pkg::RDIV_W-1:0] dsel;
    logic signed [aacr_pkg::SUM_W-1:0]  sum_s;
    logic signed [aacr_pkg::MAG_W:0]    quo;
    logic signed [RES_W-1:0]            res;
    aacr_pkg::t_pix                  n_pix;
    logic [aacr_pkg::NUM_CH-1:0]     sel;
    logic                            out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_qstat.empty;
    assign o_valid  = r_out_valid;
    assign o_pix    = r_out_pix;
    assign o_copied = r_out_copied;

    // Operand magnitudes and quotient signs for a job taken from the queue.
    always_comb begin
        for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
            sum_s      = $signed(i_job.sums[ch]);
            dsel       = (ch == aacr_pkg::CH_ALPHA) ? aacr_pkg::RDIV_W'(i_divisor)
                                                    : $signed(i_job.rdiv);
            ld_num[ch] = sum_s[aacr_pkg::SUM_W-1] ? aacr_pkg::MAG_W'(-sum_s)
                                                  : aacr_pkg::MAG_W'(sum_s);
            ld_den[ch] = dsel[aacr_pkg::RDIV_W-1] ? -dsel : dsel;
            ld_neg[ch] = sum_s[aacr_pkg::SUM_W-1] ^ dsel[aacr_pkg::RDIV_W-1];
        end
    end

    // One quotient bit per lane per cycle.
    always_comb begin
        for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
            rem_sh[ch] = {r_rem[ch][aacr_pkg::REM_W-2:0], r_num[ch][aacr_pkg::MAG_W-1]};
            ge[ch]     = rem_sh[ch] >= aacr_pkg::REM_W'(r_den[ch]);
        end
    end

    // Sign, bias, clamp and channel selection of the finished quotients.
    always_comb begin
        quo = '0;
        res = '0;
        sel = i_mask;
        sel[aacr_pkg::CH_ALPHA] = i_mask[aacr_pkg::CH_ALPHA] && (i_divisor != '0);
        for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
            quo = $signed({1'b0, r_q[ch]});
            if (r_neg[ch]) begin
                quo = -quo;
            end
            res = RES_W'(quo) + RES_W'(i_bias);
            if (r_copy || !sel[ch]) begin
                n_pix[ch] = r_center[ch];
            end else if (res < 0) begin
                n_pix[ch] = '0;
            end else if (res > RES_W'(aacr_pkg::PIX_MAX)) begin
                n_pix[ch] = aacr_pkg::PIX_MAX;
            end else begin
                n_pix[ch] = res[aacr_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_cnt   <= aacr_pkg::CNT_W'(aacr_pkg::MAG_W);
                        r_state <= (i_job.rdiv == '0) ? ST_FIN : ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == aacr_pkg::CNT_W'(1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_copy   <= (i_job.rdiv == '0);
            r_center <= i_job.center;
            r_neg    <= ld_neg;
            for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
                r_num[ch] <= ld_num[ch];
                r_den[ch] <= ld_den[ch];
                r_rem[ch] <= '0;
                r_q[ch]   <= '0;
            end
        end else if (r_state == ST_DIV) begin
            for (int ch = 0; ch < aacr_pkg::NUM_CH; ch++) begin
                r_num[ch] <= {r_num[ch][aacr_pkg::MAG_W-2:0], 1'b0};
                r_rem[ch] <= ge[ch] ? rem_sh[ch] - aacr_pkg::REM_W'(r_den[ch]) : rem_sh[ch];
                r_q[ch]   <= {r_q[ch][aacr_pkg::MAG_W-2:0], ge[ch]};
            end
        end
        if (r_state == ST_FIN && out_free) begin
            r_out_pix    <= n_pix;
            r_out_copied <= r_copy;
        end
    end

endmodule

// ----- rtl/aacr_checker.sv -----
// Port-level checker for the convolution core, bound to the top level.
module aacr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              i_last,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [aacr_pkg::PIX_W-1:0]         o_out_red,
    input logic [aacr_pkg::PIX_W-1:0]         o_out_green,
    input logic [aacr_pkg::PIX_W-1:0]         o_out_blue,
    input logic [aacr_pkg::PIX_W-1:0]         o_out_alpha,
    input logic                              o_copied
);

    // Mirror of the window length and of the windows closed but not yet delivered.
    logic [aacr_pkg::TAP_W-1:0] r_taps;
    logic [3:0]                 r_pend;
    logic                       in_acc;
    logic                       out_acc;
    logic                       closing;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign closing = in_acc &&
                     (i_last || r_taps == aacr_pkg::TAP_W'(aacr_pkg::MAX_TAPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= '0;
            r_pend <= '0;
        end else begin
            if (in_acc) begin
                r_taps <= closing ? '0 : r_taps + 1'b1;
            end
            if (closing && !out_acc) begin
                r_pend <= r_pend + 1'b1;
            end else if (out_acc && !closing) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    // No result word without a closed window behind it.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != '0))
        else $error("result word shown with no window pending");

    // With nothing pending the queue is empty, so words must be taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == '0) |-> o_ready)
        else $error("input stalled although no window is pending");

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_out_alpha) && $stable(o_copied)))
        else $error("stalled result word changed");

    // Leaving reset, no result word is offered.
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result word valid right after reset");

endmodule

bind alpha_aware_convolution_rgba_core aacr_checker u_aacr_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the alpha-aware RGBA convolution core.
module tb_top;
    import aacr_pkg::*;

    // Cycles with no handshake and no register write before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet time after the last result, covering the back-end divider latency.
    localparam int DRAIN_PAD      = 48;
    // The long receiver hold-off starts once this many words have gone in.
    localparam int HOLD_AT_WORD   = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_WORDS    = 110;
    localparam int MAX_REPORTS    = 10;

    // One window element as it crosses the input channel.
    typedef struct {
        logic [PIX_W-1:0]        red;
        logic [PIX_W-1:0]        green;
        logic [PIX_W-1:0]        blue;
        logic [PIX_W-1:0]        alpha;
        logic signed [WGT_W-1:0] weight;
        logic                    is_center;
        logic                    last;
    } t_win_word;

    // One filtered output pixel.
    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             copied;
    } t_out_pix;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Window word channel, driven at the falling edge.
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [PIX_W-1:0]        in_red    = '0;
    logic [PIX_W-1:0]        in_green  = '0;
    logic [PIX_W-1:0]        in_blue   = '0;
    logic [PIX_W-1:0]        in_alpha  = '0;
    logic signed [WGT_W-1:0] in_weight = '0;
    logic                    in_center = 1'b0;
    logic                    in_last   = 1'b0;

    // Result word channel.
    logic             res_valid;
    logic             res_ready = 1'b0;
    logic [PIX_W-1:0] res_red;
    logic [PIX_W-1:0] res_green;
    logic [PIX_W-1:0] res_blue;
    logic [PIX_W-1:0] res_alpha;
    logic             res_copied;

    // Register write port.
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_DIVISOR;
    logic [DIV_W-1:0]     cfg_data = '0;

    // Words waiting to be offered, and pixels predicted but not yet seen.
    t_win_word word_q[$];
    t_out_pix  exp_px_q[$];

    int words_queued  = 0;
    int words_offered = 0;
    int words_taken   = 0;
    int results_seen  = 0;
    int copies_seen   = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int reg_loads     = 0;

    // Sender and receiver pacing.
    int in_gap    = 0;
    int in_calm   = 0;
    int out_stall = 0;
    int out_calm  = 0;
    int hold_left = 0;
    int rx_roll   = 0;
    bit hold_done = 1'b0;

    // Divisor as last loaded, used to build windows whose running divisor hits zero.
    longint plan_div = 256;

    // Prediction state: register copies and the open window.
    logic signed [DIV_W-1:0]  pr_div  = DIVISOR_RST;
    logic signed [BIAS_W-1:0] pr_bias = BIAS_RST;
    logic [MASK_W-1:0]        pr_mask = MASK_RST;
    longint acc_red   = 0;
    longint acc_green = 0;
    longint acc_blue  = 0;
    longint acc_alpha = 0;
    longint run_div   = 0;
    logic [PIX_W-1:0] ctr_red   = '0;
    logic [PIX_W-1:0] ctr_green = '0;
    logic [PIX_W-1:0] ctr_blue  = '0;
    logic [PIX_W-1:0] ctr_alpha = '0;
    bit win_open  = 1'b0;
    int win_taps  = 0;

    t_win_word next_word;
    t_win_word taken;
    t_out_pix  folded;
    t_out_pix  want;

    alpha_aware_convolution_rgba_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_red       (in_red),
        .i_green     (in_green),
        .i_blue      (in_blue),
        .i_alpha     (in_alpha),
        .i_weight    (in_weight),
        .i_is_center (in_center),
        .i_last      (in_last),
        .o_valid     (res_valid),
        .i_ready     (res_ready),
        .o_out_red   (res_red),
        .o_out_green (res_green),
        .o_out_blue  (res_blue),
        .o_out_alpha (res_alpha),
        .o_copied    (res_copied),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturate a quotient plus bias into one color byte.
    function automatic logic [PIX_W-1:0] clip_byte(input longint v);
        if (v < 0) return '0;
        if (v > longint'(PIX_MAX)) return PIX_MAX;
        return v[PIX_W-1:0];
    endfunction

    // Fold one accepted word into the open window. Returns 1 and the output pixel when
    // the word closes the window, either by its last mark or by reaching the tap limit.
    function automatic bit fold_word(input t_win_word w, output t_out_pix px);
        longint wt;
        wt = longint'(w.weight);
        px = '{default: '0};
        // The first word after a closed window clears the sums and the center, and
        // latches the divisor; later divisor writes reach the running divisor in the next window.
        if (!win_open) begin
            acc_red   = 0;
            acc_green = 0;
            acc_blue  = 0;
            acc_alpha = 0;
            run_div   = longint'(pr_div);
            ctr_red   = '0;
            ctr_green = '0;
            ctr_blue  = '0;
            ctr_alpha = '0;
            win_taps  = 0;
            win_open  = 1'b1;
        end
        // A transparent element contributes nothing and gives up its share of the divisor.
        if (w.alpha == '0) begin
            run_div = run_div - wt;
        end else begin
            acc_red   = acc_red   + longint'(w.red)   * wt;
            acc_green = acc_green + longint'(w.green) * wt;
            acc_blue  = acc_blue  + longint'(w.blue)  * wt;
            acc_alpha = acc_alpha + longint'(w.alpha) * wt;
        end
        // The latest marked element wins when several carry the center mark.
        if (w.is_center) begin
            ctr_red   = w.red;
            ctr_green = w.green;
            ctr_blue  = w.blue;
            ctr_alpha = w.alpha;
        end
        win_taps++;
        if (!w.last && win_taps < MAX_TAPS) return 1'b0;
        win_open = 1'b0;
        if (run_div == 0) begin
            px.red    = ctr_red;
            px.green  = ctr_green;
            px.blue   = ctr_blue;
            px.alpha  = ctr_alpha;
            px.copied = 1'b1;
            return 1'b1;
        end
        px.red   = pr_mask[CH_RED]   ? clip_byte(acc_red / run_div + longint'(pr_bias))
                                     : ctr_red;
        px.green = pr_mask[CH_GREEN] ? clip_byte(acc_green / run_div + longint'(pr_bias))
                                     : ctr_green;
        px.blue  = pr_mask[CH_BLUE]  ? clip_byte(acc_blue / run_div + longint'(pr_bias))
                                     : ctr_blue;
        // Alpha divides by the register value itself, and passes through when it is zero.
        px.alpha = (pr_mask[CH_ALPHA] && pr_div != 0)
                 ? clip_byte(acc_alpha / longint'(pr_div) + longint'(pr_bias))
                 : ctr_alpha;
        px.copied = 1'b0;
        return 1'b1;
    endfunction

    // Stall lengths: mostly a few cycles, now and then a long one.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 30) return PIX_MAX;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [PIX_W-1:0] rand_alpha();
        if ($urandom_range(0, 99) < 15) return '0;
        return rand_pix();
    endfunction

    function automatic logic signed [WGT_W-1:0] rand_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return WGT_W'($urandom_range(0, 512));
        if (r < 55) return WGT_W'(-int'($urandom_range(0, 512)));
        if (r < 80) return WGT_W'($urandom);
        case ($urandom_range(0, 3))
            0: return WGT_W'(4095);
            1: return WGT_W'(-4096);
            2: return WGT_W'(0);
            default: return WGT_W'(256);
        endcase
    endfunction

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 1;
        if (r < 60) return $urandom_range(2, 9);
        if (r < 90) return $urandom_range(10, 25);
        return $urandom_range(26, 60);
    endfunction

    task automatic add_word(input logic [PIX_W-1:0] r, g, b, a, input int w,
                            input bit c, input bit l);
        t_win_word nw;
        nw.red       = r;
        nw.green     = g;
        nw.blue      = b;
        nw.alpha     = a;
        nw.weight    = WGT_W'(w);
        nw.is_center = c;
        nw.last      = l;
        word_q.push_back(nw);
        words_queued++;
    endtask

    // Load all three registers on consecutive cycles; write enable drops afterwards.
    task automatic load_regs(input int d, input int bi, input int m);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DIVISOR;
        cfg_data <= DIV_W'(d);
        @(negedge clk);
        cfg_idx  <= CFG_BIAS;
        cfg_data <= DIV_W'(bi);
        @(negedge clk);
        cfg_idx  <= CFG_MASK;
        cfg_data <= DIV_W'(m);
        @(negedge clk);
        cfg_we   <= 1'b0;
        plan_div = d;
        reg_loads++;
    endtask

    // Wait until every word is in and every predicted pixel is out, then let the
    // divider settle in case a window is still open or in flight.
    task automatic drain();
        while (words_taken != words_queued || exp_px_q.size() != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // One random window. Some windows are built so that their transparent weights
    // cancel the divisor exactly, which forces the center-copy path.
    task automatic gen_window(input int len);
        int n_zero;
        int ctr_at;
        int i;
        longint rest;
        bit copy_win;
        bit extra_ctr;
        logic [PIX_W-1:0] a;
        logic signed [WGT_W-1:0] w;
        copy_win = ($urandom_range(0, 9) == 0);
        rest = plan_div;
        n_zero = 0;
        if (copy_win) begin
            n_zero = int'(((rest < 0) ? -rest : rest) + 4094) / 4095;
            if (n_zero == 0) n_zero = 1;
            if (n_zero > 8) copy_win = 1'b0;
            else if (len < n_zero) len = n_zero;
        end
        ctr_at = ($urandom_range(0, 99) < 15) ? -1 : int'($urandom_range(0, len - 1));
        extra_ctr = ($urandom_range(0, 99) < 10);
        for (i = 0; i < len; i++) begin
            if (copy_win && i < n_zero) begin
                a = '0;
                if (rest > 4095) w = WGT_W'(4095);
                else if (rest < -4096) w = WGT_W'(-4096);
                else w = WGT_W'(rest);
                rest = rest - w;
            end else begin
                a = copy_win ? PIX_W'($urandom_range(1, 255)) : rand_alpha();
                w = rand_weight();
            end
            add_word(rand_pix(), rand_pix(), rand_pix(), a, w,
                     (i == ctr_at) || (extra_ctr && $urandom_range(0, 3) == 0),
                     i == len - 1);
        end
    endtask

    // Sender: offers the next queued word once the previous one is taken, after a
    // random gap. Calm stretches offer back to back.
    always @(negedge clk) begin
        if (!in_valid || words_taken == words_offered) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
                next_word = word_q.pop_front();
                in_red    <= next_word.red;
                in_green  <= next_word.green;
                in_blue   <= next_word.blue;
                in_alpha  <= next_word.alpha;
                in_weight <= next_word.weight;
                in_center <= next_word.is_center;
                in_last   <= next_word.last;
                in_valid  <= 1'b1;
                words_offered++;
                if (in_calm > 0) begin
                    in_calm--;
                    in_gap = 0;
                end else begin
                    if ($urandom_range(0, 99) < 2) in_calm = $urandom_range(40, 120);
                    in_gap = ($urandom_range(0, 99) < 55) ? 0 : stall_len();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off while the sender
    // keeps offering, so the job queue fills and the input side backs up.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (!hold_done && in_valid && words_taken >= HOLD_AT_WORD) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            res_ready <= 1'b0;
        end else if (out_calm > 0) begin
            out_calm--;
            res_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 2) out_calm = $urandom_range(40, 150);
            else if (rx_roll < 18) out_stall = stall_len();
            res_ready <= 1'b1;
        end
    end

    // Scoreboard: checks each result word against the oldest prediction, folds each
    // accepted input word into the predictor, mirrors register writes, and runs the
    // watchdog. Results trail their last word through the queue and the divider, so
    // checking before folding at the same edge is safe.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && res_ready) begin
                results_seen++;
                if (exp_px_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result word r=%0d g=%0d b=%0d a=%0d copied=%0b",
                                 res_red, res_green, res_blue, res_alpha, res_copied);
                end else begin
                    want = exp_px_q.pop_front();
                    if (want.copied) copies_seen++;
                    if (res_red !== want.red || res_green !== want.green ||
                        res_blue !== want.blue || res_alpha !== want.alpha ||
                        res_copied !== want.copied) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("Mismatch on result %0d: expected r=%0d g=%0d b=%0d a=%0d copied=%0b",
                                     results_seen, want.red, want.green, want.blue,
                                     want.alpha, want.copied);
                            $display("    got r=%0d g=%0d b=%0d a=%0d copied=%0b",
                                     res_red, res_green, res_blue, res_alpha, res_copied);
                        end
                    end
                end
            end
            if (in_valid && in_ready) begin
                words_taken++;
                taken.red       = in_red;
                taken.green     = in_green;
                taken.blue      = in_blue;
                taken.alpha     = in_alpha;
                taken.weight    = in_weight;
                taken.is_center = in_center;
                taken.last      = in_last;
                if (fold_word(taken, folded)) exp_px_q.push_back(folded);
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_DIVISOR: pr_div  = cfg_data;
                    CFG_BIAS:    pr_bias = cfg_data[BIAS_W-1:0];
                    CFG_MASK:    pr_mask = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if ((in_valid && in_ready) || (res_valid && res_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d predictions pending",
                         quiet_cycles, exp_px_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus sequence: directed windows under reset settings, a few register
    // sweeps with one- and two-word windows, a register write inside an open window, then
    // random phases with fresh settings each and one overlong window.
    initial begin
        int p;
        int phase_end;
        int d;
        int bi;
        int m;
        int i;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: divisor 256, bias 0, all channels filtered.
        add_word(8'd10, 8'd20, 8'd30, 8'd40, 256, 1'b1, 1'b1);
        add_word(8'd255, 8'd255, 8'd255, 8'd255, 4095, 1'b1, 1'b1);
        add_word(8'd255, 8'd255, 8'd255, 8'd255, -4096, 1'b1, 1'b1);
        // No center and a transparent element that cancels the divisor: zeros copied.
        add_word(8'd0, 8'd0, 8'd0, 8'd0, 256, 1'b0, 1'b1);
        // Two centers, the later one transparent; the running divisor reaches zero.
        add_word(8'd9, 8'd8, 8'd7, 8'd6, 0, 1'b1, 1'b0);
        add_word(8'd1, 8'd2, 8'd3, 8'd0, 256, 1'b1, 1'b0);
        add_word(8'd50, 8'd60, 8'd70, 8'd80, 0, 1'b0, 1'b1);
        // A 3x3 sharpening window with negative taps and one transparent corner.
        add_word(8'd12, 8'd200, 8'd34, 8'd255, -64, 1'b0, 1'b0);
        add_word(8'd90, 8'd91, 8'd92, 8'd93, -64, 1'b0, 1'b0);
        add_word(8'd0, 8'd0, 8'd0, 8'd0, -64, 1'b0, 1'b0);
        add_word(8'd70, 8'd20, 8'd140, 8'd128, -64, 1'b0, 1'b0);
        add_word(8'd100, 8'd120, 8'd140, 8'd200, 768, 1'b1, 1'b0);
        add_word(8'd255, 8'd0, 8'd255, 8'd1, -64, 1'b0, 1'b0);
        add_word(8'd33, 8'd66, 8'd99, 8'd132, -64, 1'b0, 1'b0);
        add_word(8'd5, 8'd250, 8'd5, 8'd250, -64, 1'b0, 1'b0);
        add_word(8'd128, 8'd128, 8'd128, 8'd128, -64, 1'b0, 1'b1);
        drain();

        // Zero divisor with only alpha selected: alpha passes the center through.
        load_regs(0, -1024, 4'b1000);
        add_word(8'd1, 8'd2, 8'd3, 8'd0, -512, 1'b0, 1'b0);
        add_word(8'd100, 8'd150, 8'd200, 8'd250, 256, 1'b1, 1'b1);
        drain();

        load_regs(1048575, 1023, 4'b0101);
        add_word(8'd255, 8'd0, 8'd255, 8'd128, 4095, 1'b1, 1'b1);
        drain();

        load_regs(-1048576, -1024, 4'b0000);
        add_word(8'd17, 8'd34, 8'd51, 8'd68, -4096, 1'b1, 1'b1);
        drain();

        // Registers rewritten while a window is open: the old divisor stays latched.
        load_regs(256, 0, 4'b1111);
        add_word(8'd40, 8'd40, 8'd40, 8'd40, 256, 1'b1, 1'b0);
        add_word(8'd80, 8'd80, 8'd80, 8'd0, 100, 1'b0, 1'b0);
        drain();
        load_regs(512, 5, 4'b1011);
        add_word(8'd60, 8'd60, 8'd60, 8'd60, 256, 1'b0, 1'b1);

        for (p = 0; p < RAND_PHASES; p++) begin
            drain();
            case ($urandom_range(0, 7))
                0: d = 256;
                1: d = 2304;
                2: d = 0;
                3: d = -256;
                4: d = $urandom_range(1, 4096);
                5: d = -int'($urandom_range(1, 4096));
                6: d = int'($signed(DIV_W'($urandom)));
                default: d = ($urandom_range(0, 1) != 0) ? 1048575 : -1048576;
            endcase
            i = $urandom_range(0, 99);
            if (i < 30) bi = 0;
            else if (i < 80) bi = int'($urandom_range(0, 128)) - 64;
            else bi = int'($signed(BIAS_W'($urandom)));
            m = $urandom_range(0, 15);
            if (p == 0) m = 15;
            if (p == 1) d = 0;
            if (p == 4) begin
                d  = 1048575;
                bi = 0;
                m  = 15;
            end
            load_regs(d, bi, m);
            // The overlong window has no last mark until well past the tap limit, so the
            // limit closes it and the tail words form a window without a center.
            if (p == 4) begin
                for (i = 0; i < MAX_TAPS + 6; i++)
                    add_word(rand_pix(), rand_pix(), rand_pix(),
                             ($urandom_range(0, 9) == 0) ? 8'd0 : PIX_MAX,
                             ($urandom_range(0, 1) != 0) ? 4095 : int'(rand_weight()),
                             i == 500, i == MAX_TAPS + 5);
            end
            phase_end = words_queued + PHASE_WORDS;
            while (words_queued < phase_end) gen_window(rand_len());
        end
        drain();

        mismatches += exp_px_q.size();
        $display("Covered %0d window words and %0d output pixels, %0d of them center copies.",
                 words_taken, results_seen, copies_seen);
        $display("Swept %0d register settings, both divisor and bias extremes and a tap overrun.",
                 reg_loads);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- alpha_aware_convolution_rgba_core.f -----
rtl/aacr_pkg.sv
rtl/aacr_front.sv
rtl/aacr_queue.sv
rtl/aacr_back.sv
rtl/alpha_aware_convolution_rgba_core.sv
rtl/aacr_checker.sv
sim/tb_top.sv
